// ===== rtl/gzhp_pkg.sv =====
// Shared types and constants of the gzip header parser.
package gzhp_pkg;

	// Width of the running header byte counter.
	localparam int OFFSET_BITS = 24;
	// Width of the reported payload offset.
	localparam int PAYLOAD_BITS = 24;
	// Width of the fixed-part and extra-field skip counter.
	localparam int SKIP_BITS = 16;

	localparam logic [7:0] MAGIC1_BYTE = 8'h1F;
	localparam logic [7:0] MAGIC2_BYTE = 8'h8B;
	localparam logic [7:0] METHOD_DEFLATE = 8'd8;
	localparam logic [SKIP_BITS-1:0] FIXED_SKIP = SKIP_BITS'(6);

	// Positions of the kept flag bits (flag byte bits 1 to 4).
	localparam int FL_HCRC = 0;
	localparam int FL_EXTRA = 1;
	localparam int FL_NAME = 2;
	localparam int FL_COMMENT = 3;

	typedef enum logic [3:0] {
		PH_MAGIC1 = 4'd0,
		PH_MAGIC2 = 4'd1,
		PH_METHOD = 4'd2,
		PH_FLAGS = 4'd3,
		PH_FIXED = 4'd4,
		PH_XLEN_LO = 4'd5,
		PH_XLEN_HI = 4'd6,
		PH_EXTRA = 4'd7,
		PH_NAME = 4'd8,
		PH_COMMENT = 4'd9,
		PH_HCRC1 = 4'd10,
		PH_HCRC2 = 4'd11,
		PH_DONE = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		SEC_EXTRA = 2'd0,
		SEC_NAME = 2'd1,
		SEC_COMMENT = 2'd2,
		SEC_HCRC = 2'd3
	} sec_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD = 2'd1,
		ST_TRUNC = 2'd2,
		ST_OVF = 2'd3
	} status_t;

	typedef struct packed {
		status_t status;
		logic [PAYLOAD_BITS-1:0] offset;
	} result_t;

endpackage

// ===== rtl/gzhp_walker.sv =====
// Header walk state and the per-byte update of the gzip header parser.
module gzhp_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_value,
	input  logic              last_byte,
	output logic              res_valid,
	output gzhp_pkg::result_t res
);

	gzhp_pkg::phase_t phase_q, phase_d;
	logic [gzhp_pkg::OFFSET_BITS-1:0] offset_q, offset_d, offset_inc;
	logic [3:0] flags_q, flags_d;
	logic [gzhp_pkg::SKIP_BITS-1:0] skip_q, skip_d, xlen_val;
	logic [7:0] xlen_lo_q, xlen_lo_d;
	logic enter_req;
	gzhp_pkg::sec_t enter_sec;
	gzhp_pkg::phase_t enter_phase;
	logic [gzhp_pkg::PAYLOAD_BITS-1:0] offset_ext;

	// First flagged optional section at or after sec, or done when none is left.
	function automatic gzhp_pkg::phase_t enter_section(input gzhp_pkg::sec_t sec,
			input logic [3:0] fl);
		gzhp_pkg::phase_t ph;
		ph = gzhp_pkg::PH_DONE;
		if (sec <= gzhp_pkg::SEC_HCRC && fl[gzhp_pkg::FL_HCRC])
			ph = gzhp_pkg::PH_HCRC1;
		if (sec <= gzhp_pkg::SEC_COMMENT && fl[gzhp_pkg::FL_COMMENT])
			ph = gzhp_pkg::PH_COMMENT;
		if (sec <= gzhp_pkg::SEC_NAME && fl[gzhp_pkg::FL_NAME])
			ph = gzhp_pkg::PH_NAME;
		if (sec <= gzhp_pkg::SEC_EXTRA && fl[gzhp_pkg::FL_EXTRA])
			ph = gzhp_pkg::PH_XLEN_LO;
		return ph;
	endfunction

	assign offset_inc = offset_q + gzhp_pkg::OFFSET_BITS'(1);
	assign offset_ext = gzhp_pkg::PAYLOAD_BITS'(offset_inc);
	assign xlen_val = {byte_value, xlen_lo_q};

	always_comb begin
		phase_d = phase_q;
		offset_d = offset_q;
		flags_d = flags_q;
		skip_d = skip_q;
		xlen_lo_d = xlen_lo_q;
		res_valid = 1'b0;
		res.status = gzhp_pkg::ST_OK;
		res.offset = '0;
		enter_req = 1'b0;
		enter_sec = gzhp_pkg::SEC_EXTRA;
		enter_phase = gzhp_pkg::PH_DONE;

		if (phase_q != gzhp_pkg::PH_DONE) begin
			if (&offset_q) begin
				res_valid = 1'b1;
				res.status = gzhp_pkg::ST_OVF;
				phase_d = gzhp_pkg::PH_DONE;
			end else begin
				offset_d = offset_inc;
				case (phase_q)
					gzhp_pkg::PH_MAGIC1: begin
						if (byte_value != gzhp_pkg::MAGIC1_BYTE) begin
							res_valid = 1'b1;
							res.status = gzhp_pkg::ST_BAD;
							phase_d = gzhp_pkg::PH_DONE;
						end else begin
							phase_d = gzhp_pkg::PH_MAGIC2;
						end
					end
					gzhp_pkg::PH_MAGIC2: begin
						if (byte_value != gzhp_pkg::MAGIC2_BYTE) begin
							res_valid = 1'b1;
							res.status = gzhp_pkg::ST_BAD;
							phase_d = gzhp_pkg::PH_DONE;
						end else begin
							phase_d = gzhp_pkg::PH_METHOD;
						end
					end
					gzhp_pkg::PH_METHOD: begin
						if (byte_value != gzhp_pkg::METHOD_DEFLATE) begin
							res_valid = 1'b1;
							res.status = gzhp_pkg::ST_BAD;
							phase_d = gzhp_pkg::PH_DONE;
						end else begin
							phase_d = gzhp_pkg::PH_FLAGS;
						end
					end
					gzhp_pkg::PH_FLAGS: begin
						flags_d = byte_value[4:1];
						skip_d = gzhp_pkg::FIXED_SKIP;
						phase_d = gzhp_pkg::PH_FIXED;
					end
					gzhp_pkg::PH_FIXED, gzhp_pkg::PH_EXTRA: begin
						if (skip_q <= gzhp_pkg::SKIP_BITS'(1)) begin
							skip_d = '0;
							enter_req = 1'b1;
							enter_sec = (phase_q == gzhp_pkg::PH_FIXED) ?
								gzhp_pkg::SEC_EXTRA : gzhp_pkg::SEC_NAME;
						end else begin
							skip_d = skip_q - gzhp_pkg::SKIP_BITS'(1);
						end
					end
					gzhp_pkg::PH_XLEN_LO: begin
						xlen_lo_d = byte_value;
						phase_d = gzhp_pkg::PH_XLEN_HI;
					end
					gzhp_pkg::PH_XLEN_HI: begin
						skip_d = xlen_val;
						if (xlen_val == '0) begin
							enter_req = 1'b1;
							enter_sec = gzhp_pkg::SEC_NAME;
						end else begin
							phase_d = gzhp_pkg::PH_EXTRA;
						end
					end
					gzhp_pkg::PH_NAME: begin
						if (byte_value == 8'd0) begin
							enter_req = 1'b1;
							enter_sec = gzhp_pkg::SEC_COMMENT;
						end
					end
					gzhp_pkg::PH_COMMENT: begin
						if (byte_value == 8'd0) begin
							enter_req = 1'b1;
							enter_sec = gzhp_pkg::SEC_HCRC;
						end
					end
					gzhp_pkg::PH_HCRC1: begin
						phase_d = gzhp_pkg::PH_HCRC2;
					end
					gzhp_pkg::PH_HCRC2: begin
						res_valid = 1'b1;
						res.offset = offset_ext;
						phase_d = gzhp_pkg::PH_DONE;
					end
					default: begin
						phase_d = phase_q;
					end
				endcase

				// Leaving a section either opens the next flagged one or ends the header.
				if (enter_req) begin
					enter_phase = enter_section(enter_sec, flags_q);
					if (enter_phase == gzhp_pkg::PH_DONE) begin
						res_valid = 1'b1;
						res.offset = offset_ext;
					end
					phase_d = enter_phase;
				end
			end
		end

		// The final byte always closes the stream and rearms the walk.
		if (last_byte) begin
			if (phase_q != gzhp_pkg::PH_DONE && !res_valid) begin
				res_valid = 1'b1;
				res.status = gzhp_pkg::ST_TRUNC;
				res.offset = '0;
			end
			phase_d = gzhp_pkg::PH_MAGIC1;
			offset_d = '0;
			flags_d = '0;
			skip_d = '0;
			xlen_lo_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gzhp_pkg::PH_MAGIC1;
			offset_q <= '0;
			flags_q <= '0;
			skip_q <= '0;
			xlen_lo_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			offset_q <= offset_d;
			flags_q <= flags_d;
			skip_q <= skip_d;
			xlen_lo_q <= xlen_lo_d;
		end
	end

endmodule

// ===== rtl/gzip_header_parser_top.sv =====
// Top level of the gzip header parser: input register, header walk and result register.
//
// The byte channel (byte_valid, byte_stall, byte_value, last_byte) takes one byte of a
// gzip stream per item, with last_byte set on the final byte of each stream. The result
// channel (result_valid, result_stall, status, payload_offset) gives one item per stream:
// status 0 with the offset of the first deflate byte, or an error code with offset 0.
// A taken byte waits in the input register; when it is walked, its result, if any, is
// registered in the result register, from which the receiver takes it.
// Throughput is one byte per cycle unless result_stall holds a result in the result register.
// After a result the remaining bytes of the stream are dropped until the final byte,
// which always rearms the walk for the next stream.
// Reset empties the input register and the result register and puts the walk back at
// the first magic byte. While result_stall holds a result, one more byte is taken into
// the input register; byte_stall then rises until the result leaves.
module gzip_header_parser_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [7:0]                        byte_value,
	input  logic                              last_byte,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [1:0]                        status,
	output logic [gzhp_pkg::PAYLOAD_BITS-1:0] payload_offset
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic step;
	logic res_valid;
	gzhp_pkg::result_t res;
	logic out_valid_q;
	gzhp_pkg::result_t out_q;

	// A held byte moves on whenever the result register is free or draining.
	assign step = valid_s1 && (!out_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	gzhp_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign status = out_q.status;
	assign payload_offset = out_q.offset;

`ifndef NO_ASSERTIONS
	// An error result never reports an offset.
	a_err_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != gzhp_pkg::ST_OK |-> out_q.offset == '0)
		else $error("error result carries a nonzero offset");

	// Back pressure only comes from a held byte that cannot move on.
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && out_valid_q && result_stall)
		else $error("byte channel stalled without a blocked byte");

	// A walked byte that ends the header shows up as a result in the next cycle.
	a_result_registered: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |=> out_valid_q)
		else $error("walk result was not registered");

	// A result is never overwritten while the receiver holds it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_stall |-> !step)
		else $error("result register overwritten while stalled");
`endif

endmodule
